/* rtl/lltd_pkg.sv */
// Package for the least-loaded task dispatcher: event and status codes,
// cell payload and control types, and the load score function. No dependencies.
package lltd_pkg;

	localparam int KIND_BITS   = 3;
	localparam int WID_BITS    = 4;
	localparam int LOAD_BITS   = 10;
	localparam int SCORE_BITS  = 14;
	localparam int STATUS_BITS = 2;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_SUBMIT  = 3'd0,
		KIND_CONNECT = 3'd1,
		KIND_IDLE    = 3'd2,
		KIND_LOAD    = 3'd3,
		KIND_FAIL    = 3'd4
	} kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVT,
		S_CHK,
		S_SCAN,
		S_SEL,
		S_DONE
	} state_t;

	// Payload of one idle-queue cell.
	typedef struct packed {
		logic [WID_BITS-1:0]   id;
		logic [SCORE_BITS-1:0] score;
	} cell_data_t;

	// Per-cell control: load from the write bus, or take the right neighbor.
	typedef struct packed {
		logic wr;
		logic shift;
	} cell_ctl_t;

	// 7*cpu + 3*mem without multipliers.
	function automatic logic [SCORE_BITS-1:0] score_f(
		input logic [LOAD_BITS-1:0] cpu,
		input logic [LOAD_BITS-1:0] mem
	);
		logic [SCORE_BITS-1:0] c;
		logic [SCORE_BITS-1:0] m;
		c = SCORE_BITS'(cpu);
		m = SCORE_BITS'(mem);
		return (c << 3) - c + (m << 1) + m;
	endfunction

endpackage

/* rtl/lltd_if.sv */
// Valid/ready channel interfaces for events and dispatch results.
// Depends on lltd_pkg for field widths.
interface lltd_evt_if #(parameter int TAG_BITS = 16);
	logic                           valid;
	logic                           ready;
	logic [lltd_pkg::KIND_BITS-1:0] kind;
	logic [TAG_BITS-1:0]            task_tag;
	logic [lltd_pkg::WID_BITS-1:0]  slot_id;
	logic [lltd_pkg::LOAD_BITS-1:0] cpu_load;
	logic [lltd_pkg::LOAD_BITS-1:0] mem_load;
	modport source (output valid, kind, task_tag, slot_id, cpu_load, mem_load, input ready);
	modport sink   (input valid, kind, task_tag, slot_id, cpu_load, mem_load, output ready);
endinterface

interface lltd_res_if #(parameter int TAG_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic                             dispatched;
	logic [TAG_BITS-1:0]              out_task;
	logic [lltd_pkg::WID_BITS-1:0]    out_worker;
	logic [lltd_pkg::SCORE_BITS-1:0]  pick_score;
	logic [lltd_pkg::STATUS_BITS-1:0] status;
	modport source (output valid, dispatched, out_task, out_worker, pick_score, status,
		input ready);
	modport sink   (input valid, dispatched, out_task, out_worker, pick_score, status,
		output ready);
endinterface

/* rtl/lltd_cell.sv */
// One idle-queue cell: holds a worker id and its score.
// Depends on lltd_pkg for the payload and control structs.
module lltd_cell (
	input  logic                 clk,
	input  lltd_pkg::cell_ctl_t  ctl,
	input  lltd_pkg::cell_data_t wr_data,
	input  lltd_pkg::cell_data_t nbr_data,
	output lltd_pkg::cell_data_t data
);
	lltd_pkg::cell_data_t data_q;

	// Payload only: occupancy lives in the queue count.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			data_q <= wr_data;
		end else if (ctl.shift) begin
			data_q <= nbr_data;
		end
	end

	assign data = data_q;
endmodule

/* rtl/lltd_task_ram.sv */
// Task deque storage: one write port, one registered read port.
// No package dependencies.
module lltd_task_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/least_loaded_task_dispatcher_core.sv */
// Least-loaded task dispatcher top level: FSM, worker tables, idle-queue cell chain.
// Depends on lltd_pkg, lltd_if, lltd_cell and lltd_task_ram.
//
//  channel | dir | transaction
//  --------+-----+--------------------------------------------------------------
//  evt     | in  | one event: kind, task_tag, slot_id, cpu_load, mem_load
//  res     | out | one result per event: dispatched, out_task, out_worker,
//          |     | pick_score, status
//
// An event passes through the event, check, scan, select and done states; the idle queue
// scan reads one cell per cycle, and an event with nothing to dispatch skips scan and select.
// Events are handled one at a time; evt.ready is high only between events.
// A finished result waits in the output register while the next event is
// accepted; the block stalls at the end of an event only if that register is full.
// Reset clears counts, worker flags and load tables; the deque and cells need none.
module least_loaded_task_dispatcher_core #(
	parameter int TASK_DEPTH  = 64,
	parameter int NUM_WORKERS = 16,
	parameter int TAG_BITS    = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	lltd_evt_if.sink   evt,
	lltd_res_if.source res
);
	localparam int AW  = (TASK_DEPTH > 1) ? $clog2(TASK_DEPTH) : 1;
	localparam int CNW = $clog2(TASK_DEPTH + 1);
	localparam int CW  = $clog2(NUM_WORKERS);
	localparam int ICW = $clog2(NUM_WORKERS + 1);
	localparam int WB  = lltd_pkg::WID_BITS;
	localparam int LB  = lltd_pkg::LOAD_BITS;
	localparam int SB  = lltd_pkg::SCORE_BITS;
	localparam int STB = lltd_pkg::STATUS_BITS;

	lltd_pkg::state_t state_q, state_d;

	// Latched event.
	logic [lltd_pkg::KIND_BITS-1:0] kind_q;
	logic [TAG_BITS-1:0]            tag_q;
	logic [WB-1:0]                  wid_q;
	logic [LB-1:0]                  cpu_in_q, mem_in_q;

	// Deque control.
	logic [AW-1:0]  head_q;
	logic [CNW-1:0] tcnt_q;

	// Worker tables and flags.
	logic [LB-1:0]          cpu_q [NUM_WORKERS];
	logic [LB-1:0]          mem_q [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] reg_q;
	logic [NUM_WORKERS-1:0] idle_q;
	logic [LB-1:0]          rd_cpu_q, rd_mem_q;

	// Idle queue.
	logic [ICW-1:0] icnt_q;
	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  best_pos_q;
	logic [SB-1:0]  best_score_q;

	// Pending result and output register.
	logic [STB-1:0]      p_status_q;
	logic                p_disp_q;
	logic [TAG_BITS-1:0] p_task_q;
	logic [WB-1:0]       p_worker_q;
	logic [SB-1:0]       p_score_q;
	logic                out_valid_q;
	logic [STB-1:0]      o_status_q;
	logic                o_disp_q;
	logic [TAG_BITS-1:0] o_task_q;
	logic [WB-1:0]       o_worker_q;
	logic [SB-1:0]       o_score_q;

	logic                in_fire, out_fire;
	logic [CW-1:0]       widx, widx_in;
	logic                slot_ok, wreg, widle, tfull, do_disp;
	logic [AW:0]         tail_sum;
	logic [AW-1:0]       tail, head_dec, head_inc;
	logic [CW-1:0]       match_pos;
	logic [STB-1:0]      evt_status;

	// Cell chain wiring.
	lltd_pkg::cell_ctl_t  ctl  [NUM_WORKERS];
	lltd_pkg::cell_data_t cdat [NUM_WORKERS];
	lltd_pkg::cell_data_t nbr  [NUM_WORKERS];
	lltd_pkg::cell_data_t wr_bus;
	logic                 c_wr, c_shift;
	logic [CW-1:0]        c_wr_pos, c_shift_pos;

	// Deque RAM.
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr;
	logic [TAG_BITS-1:0] ram_rdata;

	assign in_fire  = evt.valid && evt.ready;
	assign out_fire = out_valid_q && res.ready;
	assign widx_in  = CW'(evt.slot_id);
	assign widx     = CW'(wid_q);
	assign slot_ok  = ({{(32-WB){1'b0}}, wid_q} < 32'(NUM_WORKERS));
	assign wreg     = reg_q[widx];
	assign widle    = idle_q[widx];
	assign tfull    = (tcnt_q == CNW'(TASK_DEPTH));
	assign do_disp  = (tcnt_q != '0) && (icnt_q != '0);

	// Circular deque pointer arithmetic for any depth.
	assign tail_sum = {1'b0, head_q} + (AW+1)'(tcnt_q);
	assign tail     = (tail_sum >= (AW+1)'(TASK_DEPTH)) ?
		AW'(tail_sum - (AW+1)'(TASK_DEPTH)) : AW'(tail_sum);
	assign head_dec = (head_q == '0) ? AW'(TASK_DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(TASK_DEPTH - 1)) ? '0 : head_q + AW'(1);

	// Locate the event's worker in the idle queue (ids are unique there).
	always_comb begin
		match_pos = '0;
		for (int j = 0; j < NUM_WORKERS; j++) begin
			if ((ICW'(j) < icnt_q) && (cdat[j].id == wid_q)) begin
				match_pos = CW'(j);
			end
		end
	end

	// Status of the latched event: bad slot or unregistered worker, then a full deque.
	always_comb begin
		evt_status = lltd_pkg::ST_OK;
		case (kind_q)
			lltd_pkg::KIND_SUBMIT: begin
				if (tfull) evt_status = lltd_pkg::ST_FULL;
			end
			lltd_pkg::KIND_CONNECT, lltd_pkg::KIND_IDLE,
			lltd_pkg::KIND_LOAD, lltd_pkg::KIND_FAIL: begin
				if (!slot_ok) begin
					evt_status = lltd_pkg::ST_UNKNOWN;
				end else if ((kind_q != lltd_pkg::KIND_CONNECT) && !wreg) begin
					evt_status = lltd_pkg::ST_UNKNOWN;
				end else if ((kind_q == lltd_pkg::KIND_FAIL) && tfull) begin
					evt_status = lltd_pkg::ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lltd_pkg::S_IDLE: if (in_fire) state_d = lltd_pkg::S_EVT;
			lltd_pkg::S_EVT:  state_d = lltd_pkg::S_CHK;
			lltd_pkg::S_CHK:  state_d = do_disp ? lltd_pkg::S_SCAN : lltd_pkg::S_DONE;
			lltd_pkg::S_SCAN: if (ICW'(scan_q) == icnt_q - ICW'(1)) state_d = lltd_pkg::S_SEL;
			lltd_pkg::S_SEL:  state_d = lltd_pkg::S_DONE;
			lltd_pkg::S_DONE: if (!out_valid_q || res.ready) state_d = lltd_pkg::S_IDLE;
			default:          state_d = lltd_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, RAM strobes, cell chain control.
	always_comb begin
		evt.ready   = (state_q == lltd_pkg::S_IDLE);
		ram_we      = 1'b0;
		ram_waddr   = tail;
		ram_re      = 1'b0;
		c_wr        = 1'b0;
		c_wr_pos    = CW'(icnt_q);
		c_shift     = 1'b0;
		c_shift_pos = match_pos;
		wr_bus.id    = wid_q;
		wr_bus.score = '0;
		unique case (state_q)
			lltd_pkg::S_EVT: begin
				case (kind_q)
					lltd_pkg::KIND_SUBMIT: begin
						ram_we = !tfull;
					end
					lltd_pkg::KIND_CONNECT: begin
						// Idle worker keeps its place with a zero score; busy one appends.
						if (slot_ok) begin
							c_wr     = widle || (icnt_q < ICW'(NUM_WORKERS));
							c_wr_pos = widle ? match_pos : CW'(icnt_q);
						end
					end
					lltd_pkg::KIND_IDLE: begin
						if (slot_ok && wreg && !widle && (icnt_q < ICW'(NUM_WORKERS))) begin
							c_wr         = 1'b1;
							wr_bus.score = lltd_pkg::score_f(rd_cpu_q, rd_mem_q);
						end
					end
					lltd_pkg::KIND_LOAD: begin
						if (slot_ok && wreg && widle) begin
							c_wr         = 1'b1;
							c_wr_pos     = match_pos;
							wr_bus.score = lltd_pkg::score_f(cpu_in_q, mem_in_q);
						end
					end
					lltd_pkg::KIND_FAIL: begin
						if (slot_ok && wreg) begin
							c_shift   = widle;
							ram_we    = !tfull;
							ram_waddr = head_dec;
						end
					end
					default: ;
				endcase
			end
			lltd_pkg::S_CHK: ram_re = do_disp;
			lltd_pkg::S_SEL: begin
				c_shift     = 1'b1;
				c_shift_pos = best_pos_q;
			end
			default: ;
		endcase
	end

	// Per-cell enables: write one cell, or shift every cell at or right of the hole.
	always_comb begin
		for (int j = 0; j < NUM_WORKERS; j++) begin
			ctl[j].wr    = c_wr && (c_wr_pos == CW'(j));
			ctl[j].shift = c_shift && (CW'(j) >= c_shift_pos);
			nbr[j]       = (j == NUM_WORKERS - 1) ? '0 : cdat[(j + 1) % NUM_WORKERS];
		end
	end

	for (genvar g = 0; g < NUM_WORKERS; g++) begin : g_cell
		lltd_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[g]),
			.wr_data  (wr_bus),
			.nbr_data (nbr[g]),
			.data     (cdat[g])
		);
	end

	lltd_task_ram #(
		.DEPTH (TASK_DEPTH),
		.WIDTH (TAG_BITS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tag_q),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// Payload latches: event fields and the table read for appends.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q   <= evt.kind;
			tag_q    <= evt.task_tag;
			wid_q    <= evt.slot_id;
			cpu_in_q <= evt.cpu_load;
			mem_in_q <= evt.mem_load;
			rd_cpu_q <= cpu_q[widx_in];
			rd_mem_q <= mem_q[widx_in];
		end
	end

	// Control state, tables and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lltd_pkg::S_IDLE;
			head_q       <= '0;
			tcnt_q       <= '0;
			icnt_q       <= '0;
			reg_q        <= '0;
			idle_q       <= '0;
			scan_q       <= '0;
			best_pos_q   <= '0;
			best_score_q <= '0;
			out_valid_q  <= 1'b0;
			p_status_q   <= '0;
			p_disp_q     <= 1'b0;
			p_task_q     <= '0;
			p_worker_q   <= '0;
			p_score_q    <= '0;
			o_status_q   <= '0;
			o_disp_q     <= 1'b0;
			o_task_q     <= '0;
			o_worker_q   <= '0;
			o_score_q    <= '0;
			for (int j = 0; j < NUM_WORKERS; j++) begin
				cpu_q[j] <= '0;
				mem_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			// The done stage reloads the output register itself on a drain.
			if (out_fire && (state_q != lltd_pkg::S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lltd_pkg::S_EVT: begin
					p_status_q <= evt_status;
					p_disp_q   <= 1'b0;
					p_task_q   <= '0;
					p_worker_q <= '0;
					p_score_q  <= '0;
					case (kind_q)
						lltd_pkg::KIND_SUBMIT: begin
							if (!tfull) tcnt_q <= tcnt_q + CNW'(1);
						end
						lltd_pkg::KIND_CONNECT, lltd_pkg::KIND_IDLE,
						lltd_pkg::KIND_LOAD, lltd_pkg::KIND_FAIL: begin
							if (!slot_ok) begin
								// Drop the event.
							end else if (kind_q == lltd_pkg::KIND_CONNECT) begin
								reg_q[widx] <= 1'b1;
								cpu_q[widx] <= '0;
								mem_q[widx] <= '0;
								if (!widle && (icnt_q < ICW'(NUM_WORKERS))) begin
									idle_q[widx] <= 1'b1;
									icnt_q       <= icnt_q + ICW'(1);
								end
							end else if (!wreg) begin
								// Drop the event.
							end else if (kind_q == lltd_pkg::KIND_IDLE) begin
								if (!widle && (icnt_q < ICW'(NUM_WORKERS))) begin
									idle_q[widx] <= 1'b1;
									icnt_q       <= icnt_q + ICW'(1);
								end
							end else if (kind_q == lltd_pkg::KIND_LOAD) begin
								cpu_q[widx] <= cpu_in_q;
								mem_q[widx] <= mem_in_q;
							end else begin
								// Failure: drop from the idle queue, unregister, requeue.
								if (widle) begin
									idle_q[widx] <= 1'b0;
									icnt_q       <= icnt_q - ICW'(1);
								end
								reg_q[widx] <= 1'b0;
								if (!tfull) begin
									head_q <= head_dec;
									tcnt_q <= tcnt_q + CNW'(1);
								end
							end
						end
						default: ;
					endcase
				end
				lltd_pkg::S_CHK: begin
					scan_q <= '0;
				end
				lltd_pkg::S_SCAN: begin
					// Strict less-than keeps the earlier-queued worker on ties.
					if ((scan_q == '0) || (cdat[scan_q].score < best_score_q)) begin
						best_score_q <= cdat[scan_q].score;
						best_pos_q   <= scan_q;
					end
					scan_q <= scan_q + CW'(1);
				end
				lltd_pkg::S_SEL: begin
					p_disp_q   <= 1'b1;
					p_task_q   <= ram_rdata;
					p_worker_q <= cdat[best_pos_q].id;
					p_score_q  <= best_score_q;
					idle_q[CW'(cdat[best_pos_q].id)] <= 1'b0;
					icnt_q     <= icnt_q - ICW'(1);
					tcnt_q     <= tcnt_q - CNW'(1);
					head_q     <= head_inc;
				end
				lltd_pkg::S_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						o_status_q  <= p_status_q;
						o_disp_q    <= p_disp_q;
						o_task_q    <= p_task_q;
						o_worker_q  <= p_worker_q;
						o_score_q   <= p_score_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.valid      = out_valid_q;
	assign res.dispatched = o_disp_q;
	assign res.out_task   = o_task_q;
	assign res.out_worker = o_worker_q;
	assign res.pick_score = o_score_q;
	assign res.status     = o_status_q;

	// Hold queue counts within their capacities.
	a_icnt: assert property (@(posedge clk) disable iff (!arst_n)
		icnt_q <= ICW'(NUM_WORKERS)) else $error("idle queue overflow");
	a_tcnt: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= CNW'(TASK_DEPTH)) else $error("task deque overflow");
	// Dispatch only with a task and an idle worker on hand.
	a_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lltd_pkg::S_SEL) |-> (icnt_q != '0) && (tcnt_q != '0))
		else $error("dispatch with an empty queue");
	// Idle flags match the queue occupancy.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lltd_pkg::S_IDLE) |-> ($countones(idle_q) == int'(icnt_q)))
		else $error("idle flags disagree with queue count");
	// An accepted event always enters the event stage.
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == lltd_pkg::S_EVT)) else $error("event lost");
endmodule
